>>> hw/rtl/asd_pkg.sv
`default_nettype none
package asd_pkg;
    localparam int LEVEL_W = 24;
    localparam int THR_W   = 14;

    localparam logic [1:0] PH_RISE1 = 2'd0;
    localparam logic [1:0] PH_RISE2 = 2'd1;
    localparam logic [1:0] PH_FALL1 = 2'd2;
    localparam logic [1:0] PH_FALL2 = 2'd3;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_NINE   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [2:0] EV_NONE  = 3'd0;
    localparam logic [2:0] EV_STEP  = 3'd1;
    localparam logic [2:0] EV_NINE  = 3'd2;
    localparam logic [2:0] EV_IDLE  = 3'd3;
    localparam logic [2:0] EV_TOUT  = 3'd4;

    localparam logic [2:0] REG_IDLE_RST  = 3'd0;
    localparam logic [2:0] REG_LONG_IDLE = 3'd1;
    localparam logic [2:0] REG_STALL     = 3'd2;
    localparam logic [2:0] REG_RISE1     = 3'd3;
    localparam logic [2:0] REG_RISE2     = 3'd4;
    localparam logic [2:0] REG_FALL1     = 3'd5;
    localparam logic [2:0] REG_FALL2     = 3'd6;

    localparam logic [4:0] GAIN_DEFAULT = 5'd16;

    // Interval tolerance bounds for last intervals 6..24
    function automatic logic signed [4:0] tol_low(input logic [4:0] k);
        case (k)
            5'd0, 5'd1, 5'd2, 5'd3: tol_low = -5'sd1;
            5'd4, 5'd5:             tol_low = -5'sd2;
            5'd6, 5'd7, 5'd8:       tol_low = -5'sd3;
            5'd9, 5'd10, 5'd11, 5'd12: tol_low = -5'sd4;
            5'd13: tol_low = -5'sd5;
            5'd14: tol_low = -5'sd6;
            5'd15: tol_low = -5'sd7;
            5'd16: tol_low = -5'sd8;
            5'd17: tol_low = -5'sd9;
            default: tol_low = -5'sd10;
        endcase
    endfunction

    function automatic logic signed [4:0] tol_high(input logic [4:0] k);
        case (k)
            5'd0, 5'd1: tol_high = 5'sd2;
            5'd2:       tol_high = 5'sd3;
            5'd3, 5'd4, 5'd5, 5'd6: tol_high = 5'sd4;
            5'd7:  tol_high = 5'sd5;
            5'd8:  tol_high = 5'sd6;
            5'd9, 5'd10, 5'd11, 5'd12: tol_high = 5'sd5;
            5'd13: tol_high = 5'sd4;
            5'd14, 5'd15: tol_high = 5'sd3;
            5'd16: tol_high = 5'sd2;
            5'd17: tol_high = 5'sd1;
            default: tol_high = 5'sd0;
        endcase
    endfunction

    function automatic logic [4:0] gain_for(input logic [6:0] iv);
        if (iv <= 7'd8)       gain_for = 5'd12;
        else if (iv <= 7'd10) gain_for = 5'd14;
        else if (iv <= 7'd12) gain_for = 5'd15;
        else                  gain_for = 5'd16;
    endfunction

    // Threshold offsets {first, second} by cadence
    function automatic logic [19:0] thr_offs(input logic [6:0] avr);
        if (avr >= 7'd15)      thr_offs = {10'h000, 10'h000};
        else if (avr >= 7'd12) thr_offs = {10'h030, 10'h030};
        else if (avr >= 7'd10) thr_offs = {10'h080, 10'h060};
        else if (avr >= 7'd8)  thr_offs = {10'h110, 10'h0E0};
        else                   thr_offs = {10'h220, 10'h140};
    endfunction
endpackage
`default_nettype wire

>>> hw/rtl/asd_mac.sv
`default_nettype none
// Shared signed multiply-accumulate: one product per cycle while enabled
module asd_mac
    import asd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_clr,
    input  wire logic               i_en,
    input  wire logic signed [25:0] i_a,
    input  wire logic signed [17:0] i_b,
    output logic signed [47:0]      o_acc
);
    logic signed [47:0] r_acc;
    logic signed [43:0] w_prod;

    assign w_prod = i_a * i_b;

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_acc <= '0;
        end else if (i_en) begin
            r_acc <= r_acc + 48'(w_prod);
        end
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

>>> hw/rtl/accel_step_detector_top.sv
`default_nettype none
// Step detector: one result per sample, through the square, smooth, filter, divide and detect
// steps; requests are taken only in the idle state; the result register lets the next request
// in while a result waits, and a second result holds in the detect step until taken.
// The shared multiplier runs the three squares and the two filter products one per
// cycle; divide by 20 is a separate exact reciprocal multiply in the divide step.
// Synchronous active-low reset restores defaults except sample, mode and new-level registers.
module accel_step_detector_top
    import asd_pkg::*;
#(
    parameter int AXIS_WIDTH    = 8,
    parameter int COUNTER_WIDTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // accel_x, accel_y, accel_z, then zero fill
    input  wire logic [((3*AXIS_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    // mode
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // event_code, zero fill
    output logic [7:0]       m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    localparam int AW = AXIS_WIDTH;
    localparam int CW = COUNTER_WIDTH;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQX  = 4'd1;
    localparam logic [3:0] ST_SQY  = 4'd2;
    localparam logic [3:0] ST_SQZ  = 4'd3;
    localparam logic [3:0] ST_SMO  = 4'd4;
    localparam logic [3:0] ST_FA   = 4'd5;
    localparam logic [3:0] ST_FB   = 4'd6;
    localparam logic [3:0] ST_DIV  = 4'd7;
    localparam logic [3:0] ST_DET  = 4'd8;

    logic [3:0] r_st;
    logic [15:0] r_idle_lim, r_long_lim, r_stall_lim;
    logic [11:0] r_rb1, r_rb2, r_fb1, r_fb2;
    logic signed [AW-1:0] r_ax, r_ay, r_az;
    logic [1:0] r_mode;
    logic [16:0] r_smooth;
    logic signed [LEVEL_W-1:0] r_hist [4];
    logic [1:0] r_hpos, r_phase;
    logic signed [LEVEL_W-1:0] r_min, r_max, r_cmp;
    logic [THR_W-1:0] r_thr [4];
    logic [4:0] r_gain;
    logic [3:0] r_run;
    logic [6:0] r_ivc, r_last;
    logic [CW-1:0] r_ptime, r_itime;
    logic [2:0] r_ev;
    logic r_ovalid;
    logic signed [LEVEL_W-1:0] r_nv;

    logic mac_clr, mac_en;
    logic signed [25:0] mac_a;
    logic signed [17:0] mac_b;
    logic signed [47:0] mac_acc;

    asd_mac u_mac (
        .i_clk(i_clk), .i_clr(mac_clr), .i_en(mac_en),
        .i_a(mac_a), .i_b(mac_b), .o_acc(mac_acc)
    );

    logic [1:0] w_p1, w_p2;
    assign w_p1 = r_hpos - 2'd1;
    assign w_p2 = r_hpos - 2'd2;

    // ceil(2^32/20): exact quotient for magnitudes below 2^30
    localparam logic [27:0] RECIP20 = 28'd214748365;
    logic [29:0] w_mag;
    logic [57:0] w_qprod;
    logic [25:0] w_q;
    assign w_mag = mac_acc[47] ? 30'(-mac_acc) : 30'(mac_acc);

    always_comb begin
        mac_clr = 1'b0; mac_en = 1'b0; mac_a = '0; mac_b = '0;
        case (r_st)
            ST_IDLE: mac_clr = 1'b1;
            ST_SQX: begin mac_en = 1'b1; mac_a = 26'(r_ax); mac_b = 18'(r_ax); end
            ST_SQY: begin mac_en = 1'b1; mac_a = 26'(r_ay); mac_b = 18'(r_ay); end
            ST_SQZ: begin mac_en = 1'b1; mac_a = 26'(r_az); mac_b = 18'(r_az); end
            ST_SMO: mac_clr = 1'b1;
            ST_FA: begin
                mac_en = 1'b1;
                mac_a = 26'(r_hist[w_p1]) * 26'sd2 - 26'(r_hist[w_p2]);
                mac_b = $signed({13'd0, r_gain});
            end
            ST_FB: begin
                mac_en = 1'b1;
                mac_a = $signed({9'd0, r_smooth});
                mac_b = $signed({13'd0, 5'd20 - r_gain});
            end
            default: ;
        endcase
    end

    // quotient magnitude from the accumulator, registered in ST_DIV
    assign w_qprod = 58'(w_mag) * 58'(RECIP20);
    assign w_q = w_qprod[57:32];

    logic signed [LEVEL_W-1:0] w_nv;
    logic signed [27:0] w_sq;
    always_comb begin
        w_sq = mac_acc[47] ? -$signed({2'b0, w_q}) : $signed({2'b0, w_q});
        if (w_sq > 28'sd8388607) w_nv = 24'sh7FFFFF;
        else if (w_sq < -28'sd8388608) w_nv = 24'sh800000;
        else w_nv = w_sq[23:0];
    end

    // commit the detect step only when the result register is free or its result is being taken
    logic w_commit;
    assign w_commit = (r_st == ST_DET) && (!r_ovalid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_idle_lim <= 16'd50; r_long_lim <= 16'd1500; r_stall_lim <= 16'd300;
            r_rb1 <= 12'd368; r_rb2 <= 12'd160; r_fb1 <= 12'd368; r_fb2 <= 12'd160;
            r_smooth <= '0;
            for (int i = 0; i < 4; i++) r_hist[i] <= '0;
            r_hpos <= '0; r_phase <= PH_RISE1;
            r_min <= 24'sd32767; r_max <= -24'sd32767; r_cmp <= '0;
            r_thr[0] <= 14'd368; r_thr[1] <= 14'd160;
            r_thr[2] <= 14'd368; r_thr[3] <= 14'd160;
            r_gain <= GAIN_DEFAULT; r_run <= '0; r_ivc <= '0; r_last <= '0;
            r_ptime <= '0; r_itime <= '0; r_ev <= EV_NONE;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_IDLE_RST:  r_idle_lim <= i_cfg_data;
                    REG_LONG_IDLE: r_long_lim <= i_cfg_data;
                    REG_STALL:     r_stall_lim <= i_cfg_data;
                    REG_RISE1:     r_rb1 <= i_cfg_data[11:0];
                    REG_RISE2:     r_rb2 <= i_cfg_data[11:0];
                    REG_FALL1:     r_fb1 <= i_cfg_data[11:0];
                    REG_FALL2:     r_fb2 <= i_cfg_data[11:0];
                    default: ;
                endcase
            end
            if (w_commit) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            case (r_st)
                ST_IDLE: if (s_axis_tvalid) begin
                    r_ax <= s_axis_tdata[AW-1:0];
                    r_ay <= s_axis_tdata[2*AW-1:AW];
                    r_az <= s_axis_tdata[3*AW-1:2*AW];
                    r_mode <= s_axis_tuser;
                    r_st <= ST_SQX;
                end
                ST_SQX: r_st <= ST_SQY;
                ST_SQY: r_st <= ST_SQZ;
                ST_SQZ: r_st <= ST_SMO;
                ST_SMO: begin
                    logic [33:0] s;
                    s = (34'(r_smooth) * 34'd3 + 34'(mac_acc[32:0])) >> 2;
                    r_smooth <= (s > 34'd131071) ? 17'h1FFFF : s[16:0];
                    r_st <= ST_FA;
                end
                ST_FA: r_st <= ST_FB;
                ST_FB: r_st <= ST_DIV;
                ST_DIV: begin
                    r_nv <= w_nv;
                    r_st <= ST_DET;
                end
                ST_DET: begin : det
                    logic signed [LEVEL_W-1:0] h [4];
                    logic signed [LEVEL_W+1:0] lvl;
                    logic [1:0] ph;
                    logic signed [LEVEL_W-1:0] mn, mx, cp;
                    logic [CW-1:0] pt, it;
                    logic [6:0] iv, li;
                    logic [3:0] rn;
                    logic [4:0] gn;
                    logic [2:0] ev;
                    logic [19:0] off;
                    logic [THR_W-1:0] t0, t1, t2, t3;
                    logic over;
                    logic signed [7:0] d;
                    for (int i = 0; i < 4; i++) h[i] = r_hist[i];
                    h[r_hpos] = r_nv;
                    lvl = '0;
                    for (int i = 0; i < 4; i++)
                        lvl = lvl + 26'(h[i] / 4);
                    ph = r_phase; pt = r_ptime; it = r_itime;
                    mn = r_min; mx = r_max; cp = r_cmp;
                    iv = r_ivc; li = r_last; rn = r_run; gn = r_gain; ev = EV_NONE;
                    t0 = r_thr[0]; t1 = r_thr[1]; t2 = r_thr[2]; t3 = r_thr[3];
                    if (r_mode == MODE_CLEAR) begin
                        it = '0; pt = '0; ph = PH_RISE1;
                    end
                    if (iv < 7'd127) iv = iv + 7'd1;
                    case (ph)
                        PH_RISE1: begin
                            if (26'(mn) > lvl) mn = lvl[23:0];
                            else begin
                                pt = (pt == CMAX) ? pt : pt + 1'b1;
                                if (lvl - 26'(mn) > $signed({12'd0, t0})) begin
                                    cp = lvl[23:0]; ph = PH_RISE2;
                                end
                            end
                        end
                        PH_RISE2: begin
                            if (lvl - 26'(cp) > $signed({12'd0, t1})) begin
                                ph = PH_FALL1; mx = -24'sd32767; pt = '0;
                            end else begin
                                over = pt > CW'(7);
                                pt = (pt == CMAX) ? pt : pt + 1'b1;
                                if (over) begin ph = PH_RISE1; mn = 24'sd32767; end
                            end
                        end
                        PH_FALL1: begin
                            if (lvl > 26'(mx)) mx = lvl[23:0];
                            else if (lvl < 26'(mx) - $signed({12'd0, t2})) begin
                                cp = lvl[23:0]; ph = PH_FALL2; pt = '0;
                            end else begin
                                over = pt > CW'(7);
                                pt = (pt == CMAX) ? pt : pt + 1'b1;
                                if (over) begin ph = PH_RISE1; mn = 24'sd32767; end
                            end
                        end
                        default: begin
                            if (lvl < 26'(cp) - $signed({12'd0, t3})) begin
                                ph = PH_RISE1; mn = 24'sd32767; pt = '0; it = '0;
                                if (r_mode == MODE_NINE) begin
                                    rn = rn + 4'd1;
                                    if (rn == 4'd3) li = iv;
                                    else if (rn > 4'd3) begin
                                        d = $signed({1'b0, iv}) - $signed({1'b0, li});
                                        if (li >= 7'd6 && li <= 7'd24) begin
                                            if (d < 8'(tol_low(5'(li - 7'd6))) ||
                                                d > 8'(tol_high(5'(li - 7'd6))))
                                                rn = '0;
                                        end else if (rn > 4'd0) rn = rn - 4'd1;
                                        if (iv < 7'd6 || iv > 7'd24) rn = '0;
                                    end
                                    if (rn > 4'd0) gn = gain_for(iv);
                                    if (rn >= 4'd9) begin rn = '0; ev = EV_NINE; end
                                end else if (r_mode == MODE_NORMAL) begin
                                    if (iv >= 7'd6) begin ev = EV_STEP; gn = gain_for(iv); end
                                end
                                li = iv;
                                off = thr_offs(li);
                                t0 = 14'(r_rb1) + 14'(off[19:10]);
                                t1 = 14'(r_rb2) + 14'(off[9:0]);
                                t2 = 14'(r_fb1) + 14'(off[19:10]);
                                t3 = 14'(r_fb2) + 14'(off[9:0]);
                                iv = '0;
                            end else begin
                                over = pt > CW'(6);
                                pt = (pt == CMAX) ? pt : pt + 1'b1;
                                if (over) begin ph = PH_RISE1; mn = 24'sd32767; end
                            end
                        end
                    endcase
                    it = (it == CMAX) ? it : it + 1'b1;
                    if (32'(it) == 32'(r_idle_lim)) begin
                        t0 = 14'(r_rb1); t1 = 14'(r_rb2); t2 = 14'(r_fb1); t3 = 14'(r_fb2);
                        ph = PH_RISE1; mn = 24'sd255; rn = '0; ev = EV_IDLE;
                        gn = GAIN_DEFAULT;
                    end
                    if (32'(pt) > 32'(r_stall_lim) || 32'(it) > 32'(r_long_lim)) begin
                        ev = EV_TOUT; gn = GAIN_DEFAULT;
                    end
                    // hold here while the previous result waits
                    if (w_commit) begin
                        r_hist[r_hpos] <= r_nv;
                        r_hpos <= r_hpos + 2'd1;
                        r_phase <= ph; r_ptime <= pt; r_itime <= it;
                        r_min <= mn; r_max <= mx; r_cmp <= cp;
                        r_ivc <= iv; r_last <= li; r_run <= rn; r_gain <= gn;
                        r_thr[0] <= t0; r_thr[1] <= t1; r_thr[2] <= t2; r_thr[3] <= t3;
                        r_ev <= ev;
                        r_st <= ST_IDLE;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_st == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {5'd0, r_ev};

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("waiting result changed or dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == ST_DET) |=> m_axis_tvalid)
        else $error("result not presented after detect");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (r_ev <= EV_TOUT))
        else $error("bad event code");
endmodule
`default_nettype wire
